@@ hw/rtl/priority_backoff_window_table_macros.svh @@
// assertion macros for the priority backoff window table
// used by the port checker; no other dependencies
`ifndef PRIORITY_BACKOFF_WINDOW_TABLE_MACROS_SVH
`define PRIORITY_BACKOFF_WINDOW_TABLE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PBWT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PBWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pbwt_pkg.sv @@
// shared types, constants and spread tables of the backoff window table
// no dependencies
package pbwt_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int CLS_W       = 3;
    localparam int LIMIT_W     = 7;
    localparam int LOW_W       = 8;
    localparam int SPREAD_W    = 5;
    localparam int COLL_W      = 8;
    localparam int SUCC_W      = 2;

    // event kinds
    localparam logic MODE_FAIL    = 1'b0;
    localparam logic MODE_SUCCESS = 1'b1;

    localparam logic [SUCC_W-1:0] SUCC_WRAP  = 2'd3;
    localparam logic [COLL_W-1:0] COLL_MAX   = 8'hFF;
    localparam logic [COLL_W-1:0] COLL_TABLE = 8'd4;

    // limits after reset, class 0 first
    localparam logic [LIMIT_W-1:0] LIMIT_RESET [MAX_CLASSES] =
        '{7'd64, 7'd60, 7'd56, 7'd52, 7'd46, 7'd38, 7'd28, 7'd16};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RIPPLE,
        ST_EMIT
    } t_state;

    // event broadcast to every cell
    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [CLS_W-1:0] cls;
    } t_evt;

    // limit write broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [CLS_W-1:0]   index;
        logic [LIMIT_W-1:0] data;
    } t_cfg_wr;

    // window top handed to the next lower class
    typedef struct packed {
        logic               valid;
        logic [LIMIT_W-1:0] high;
    } t_chain;

    // what a cell shows for readout
    typedef struct packed {
        logic [LOW_W-1:0]    low;
        logic [LIMIT_W-1:0]  high;
        logic [SPREAD_W-1:0] spread;
    } t_view;

    typedef struct packed {
        logic [LOW_W-1:0]   low;
        logic [LIMIT_W-1:0] high;
    } t_window;

    // spread after a failure, for collision counts 1 to 4
    function automatic logic [SPREAD_W-1:0] widen_spread(input logic [2:0] c);
        logic [SPREAD_W-1:0] s;
        unique case (c)
            3'd0:    s = 5'd1;
            3'd1:    s = 5'd3;
            3'd2:    s = 5'd6;
            3'd3:    s = 5'd10;
            default: s = 5'd16;
        endcase
        return s;
    endfunction

    // spread after every third success, for collision counts 0 to 4
    function automatic logic [SPREAD_W-1:0] narrow_spread(input logic [2:0] c);
        logic [SPREAD_W-1:0] s;
        unique case (c)
            3'd0:    s = 5'd1;
            3'd1:    s = 5'd1;
            3'd2:    s = 5'd3;
            3'd3:    s = 5'd6;
            default: s = 5'd10;
        endcase
        return s;
    endfunction

    // reset window of one class: chain from the top class with spread one
    function automatic t_window reset_window(input int cls, input int count);
        t_window            w;
        logic [LOW_W-1:0]   lo;
        logic [LOW_W:0]     sum;
        logic [LIMIT_W-1:0] hi;
        hi  = '0;
        lo  = 8'd1;
        sum = '0;
        for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
            if (i < count && i >= cls) begin
                if (i != count - 1) begin
                    lo = LOW_W'(hi) + 8'd1;
                end
                sum = 9'(lo) + 9'd1;
                hi  = (sum < 9'(LIMIT_RESET[i])) ? sum[LIMIT_W-1:0] : LIMIT_RESET[i];
            end
        end
        w.low  = lo;
        w.high = hi;
        return w;
    endfunction

endpackage

@@ hw/rtl/pbwt_if.sv @@
// handshake channels of the backoff window table: events, windows, limit writes
// depends on pbwt_pkg
interface pbwt_in_if import pbwt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [CLS_W-1:0] priority_req;

    modport source (output valid, output mode, output priority_req, input ready);
    modport sink   (input valid, input mode, input priority_req, output ready);
endinterface

interface pbwt_out_if import pbwt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CLS_W-1:0]    class_index;
    logic [LOW_W-1:0]    window_low;
    logic [LIMIT_W-1:0]  window_high;
    logic [SPREAD_W-1:0] spread;
    logic                last;

    modport source (output valid, output class_index, output window_low,
                    output window_high, output spread, output last, input ready);
    modport sink   (input valid, input class_index, input window_low,
                    input window_high, input spread, input last, output ready);
endinterface

interface pbwt_cfg_if import pbwt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CLS_W-1:0]   index;
    logic [LIMIT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/priority_backoff_window_table.sv @@
// Backoff window table for CLASS_COUNT priority classes, one cell per class in a
// chain running from the top class down to class 0. An event word is taken only
// while the block is idle. A success, or a class at or above CLASS_COUNT, goes
// straight to readout; a failure on class c first ripples the new window top down
// the cell chain, one cell per cycle, down to class 0. Readout then hands out
// CLASS_COUNT window words, class 0 first, one per cycle while the sink is ready.
// Limit writes are taken every cycle and act at the next recomputation of that
// class's window.
// depends on pbwt_pkg, pbwt_if and pbwt_cell
module priority_backoff_window_table import pbwt_pkg::*; #(
    parameter int CLASS_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbwt_in_if.sink           i_evt,
    pbwt_out_if.source        o_win,
    pbwt_cfg_if.sink          i_cfg
);

    localparam int                IDX_W    = $clog2(CLASS_COUNT);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CLASS_COUNT - 1);
    localparam logic [IDX_W-1:0]  ONE_IDX  = IDX_W'(1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_left,  n_left;
    logic [IDX_W-1:0]   r_idx,   n_idx;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_in_range;
    logic               w_ripple;
    t_evt               w_evt;
    t_cfg_wr            w_cfg;
    t_chain             w_chain [CLASS_COUNT+1];
    t_view              w_view  [CLASS_COUNT];

    assign w_in_acc   = i_evt.valid && i_evt.ready;
    assign w_out_acc  = o_win.valid && o_win.ready;
    assign w_in_range = 4'(i_evt.priority_req) < 4'(CLASS_COUNT);
    assign w_ripple   = (i_evt.mode == MODE_FAIL) && w_in_range &&
                        (i_evt.priority_req != '0);

    // broadcasts to the cells
    assign w_evt.valid = w_in_acc && w_in_range;
    assign w_evt.mode  = i_evt.mode;
    assign w_evt.cls   = i_evt.priority_req;

    assign i_cfg.ready = 1'b1;
    assign w_cfg.en    = i_cfg.valid;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;

    // cell chain, top class has no upper neighbor
    assign w_chain[CLASS_COUNT] = '0;

    for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_cell
        pbwt_cell #(
            .IDX         (g),
            .CLASS_COUNT (CLASS_COUNT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_evt   (w_evt),
            .i_cfg   (w_cfg),
            .i_chain (w_chain[g+1]),
            .o_chain (w_chain[g]),
            .o_view  (w_view[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_ripple ? ST_RIPPLE : ST_EMIT;
                end
            end
            ST_RIPPLE: begin
                if (r_left == ONE_IDX) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && (r_idx == LAST_IDX)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_evt.ready = 1'b0;
        o_win.valid = 1'b0;
        unique case (r_state)
            ST_IDLE:   i_evt.ready = 1'b1;
            ST_EMIT:   o_win.valid = 1'b1;
            default: begin
                i_evt.ready = 1'b0;
                o_win.valid = 1'b0;
            end
        endcase
    end

    // ripple countdown and readout index
    always_comb begin
        n_left = r_left;
        n_idx  = r_idx;
        if (w_in_acc) begin
            n_left = i_evt.priority_req[IDX_W-1:0];
            n_idx  = '0;
        end else if (r_state == ST_RIPPLE) begin
            n_left = r_left - ONE_IDX;
        end
        if (w_out_acc) begin
            n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + ONE_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_idx   <= n_idx;
        end
    end

    // window word for the class under readout
    assign o_win.class_index = CLS_W'(r_idx);
    assign o_win.window_low  = w_view[r_idx].low;
    assign o_win.window_high = w_view[r_idx].high;
    assign o_win.spread      = w_view[r_idx].spread;
    assign o_win.last        = (r_idx == LAST_IDX);

endmodule

@@ hw/rtl/pbwt_cell.sv @@
// one class of the window table: counts, spread, limit and window
// depends on pbwt_pkg; the cells form a chain from the top class downward
module pbwt_cell import pbwt_pkg::*; #(
    parameter int IDX         = 0,
    parameter int CLASS_COUNT = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_evt    i_evt,
    input  t_cfg_wr i_cfg,
    input  t_chain  i_chain,
    output t_chain  o_chain,
    output t_view   o_view
);

    localparam t_window RST_WIN = reset_window(IDX, CLASS_COUNT);

    logic [LIMIT_W-1:0]  r_limit,  n_limit;
    logic [SPREAD_W-1:0] r_spread, n_spread;
    logic [COLL_W-1:0]   r_coll,   n_coll;
    logic [SUCC_W-1:0]   r_succ,   n_succ;
    logic [LOW_W-1:0]    r_low,    n_low;
    logic [LIMIT_W-1:0]  r_high,   n_high;
    t_chain              r_pass,   n_pass;

    logic               w_hit;
    logic               w_fail;
    logic [COLL_W-1:0]  w_coll_inc;
    logic [COLL_W-1:0]  w_coll_dec;
    logic [SUCC_W-1:0]  w_succ_inc;
    logic [LOW_W-1:0]   w_base_low;
    logic [LOW_W:0]     w_sum;
    logic [LIMIT_W-1:0] w_cap;

    assign w_hit      = i_evt.valid && (i_evt.cls == CLS_W'(IDX));
    assign w_fail     = w_hit && (i_evt.mode == MODE_FAIL);
    assign w_coll_inc = (r_coll == COLL_MAX) ? r_coll : r_coll + 8'd1;
    assign w_coll_dec = (r_coll != '0) ? r_coll - 8'd1 : r_coll;
    assign w_succ_inc = r_succ + 2'd1;

    // counts and spread of this class
    always_comb begin
        n_coll   = r_coll;
        n_succ   = r_succ;
        n_spread = r_spread;
        if (w_hit) begin
            if (i_evt.mode == MODE_FAIL) begin
                n_coll = w_coll_inc;
                if (w_coll_inc <= COLL_TABLE) begin
                    n_spread = widen_spread(w_coll_inc[2:0]);
                end
            end else if (w_succ_inc != SUCC_WRAP) begin
                n_succ = w_succ_inc;
            end else begin
                n_succ = '0;
                n_coll = w_coll_dec;
                if (w_coll_dec <= COLL_TABLE) begin
                    n_spread = narrow_spread(w_coll_dec[2:0]);
                end
            end
        end
    end

    // window top: base is own low on a failure, one above the upper neighbor on a ripple
    assign w_base_low = i_chain.valid ? (LOW_W'(i_chain.high) + 8'd1) : r_low;
    assign w_sum      = 9'(w_base_low) + 9'(n_spread);
    assign w_cap      = (w_sum < 9'(r_limit)) ? w_sum[LIMIT_W-1:0] : r_limit;

    always_comb begin
        n_low        = r_low;
        n_high       = r_high;
        n_pass.valid = 1'b0;
        n_pass.high  = r_high;
        if (w_fail || i_chain.valid) begin
            n_low        = w_base_low;
            n_high       = w_cap;
            n_pass.valid = 1'b1;
            n_pass.high  = w_cap;
        end
    end

    // limit register
    always_comb begin
        n_limit = r_limit;
        if (i_cfg.en && (i_cfg.index == CLS_W'(IDX))) begin
            n_limit = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET[IDX];
            r_spread <= 5'd1;
            r_coll   <= '0;
            r_succ   <= '0;
            r_low    <= RST_WIN.low;
            r_high   <= RST_WIN.high;
            r_pass   <= '0;
        end else begin
            r_limit  <= n_limit;
            r_spread <= n_spread;
            r_coll   <= n_coll;
            r_succ   <= n_succ;
            r_low    <= n_low;
            r_high   <= n_high;
            r_pass   <= n_pass;
        end
    end

    assign o_chain       = r_pass;
    assign o_view.low    = r_low;
    assign o_view.high   = r_high;
    assign o_view.spread = r_spread;

endmodule

@@ hw/rtl/pbwt_checker.sv @@
// port checker for the backoff window table, bound to the top level
// depends on pbwt_pkg and the assertion macros header
`include "priority_backoff_window_table_macros.svh"

module pbwt_checker import pbwt_pkg::*; #(
    parameter int CLASS_COUNT = 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CLS_W-1:0] i_out_class,
    input logic             i_out_last
);

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // no new event while a readout is under way
    `PBWT_ASSERT_NOW(a_no_accept_in_readout, i_clk, i_rst_n, i_out_valid, !i_in_ready, "event taken during readout")

    // the last word belongs to the top class
    `PBWT_ASSERT_NOW(a_last_is_top, i_clk, i_rst_n, i_out_valid && i_out_last, i_out_class == CLS_W'(CLASS_COUNT - 1), "last word not on top class")

    // classes come out in ascending order without gaps
    `PBWT_ASSERT_NEXT(a_class_steps, i_clk, i_rst_n, w_out_acc && !i_out_last, i_out_valid && (i_out_class == $past(i_out_class) + 3'd1), "class order broken")

    // after the last word the block is idle again
    `PBWT_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, w_out_acc && i_out_last, i_in_ready && !i_out_valid, "not idle after readout")

    // an accepted event keeps the block busy
    `PBWT_ASSERT_NEXT(a_busy_after_event, i_clk, i_rst_n, w_in_acc, !i_in_ready, "ready right after event")

endmodule

bind priority_backoff_window_table pbwt_checker #(
    .CLASS_COUNT (CLASS_COUNT)
) u_pbwt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_out_valid (o_win.valid),
    .i_out_ready (o_win.ready),
    .i_out_class (o_win.class_index),
    .i_out_last  (o_win.last)
);

@@ tb/tb.sv @@
// self-checking testbench for priority_backoff_window_table: events in, window words out
// keeps its own copy of the window table and compares every window word field by field
// depends on pbwt_pkg, pbwt_if and the block itself
module tb;
    import pbwt_pkg::*;

    localparam int CLASSES       = 8;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_MARGIN  = 24;
    localparam int RUN_LIMIT     = 8_000_000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_EVENTS  = 20;
    localparam int HOLD_OFF      = 400;
    localparam int WORD_SLOTS    = 64;

    // spread for collision counts 0 to 4, after a failure and after a third success
    localparam logic [SPREAD_W-1:0] SPREAD_UP [5]   = '{5'd1, 5'd3, 5'd6, 5'd10, 5'd16};
    localparam logic [SPREAD_W-1:0] SPREAD_DOWN [5] = '{5'd1, 5'd1, 5'd3, 5'd6, 5'd10};

    typedef struct packed {
        logic [CLS_W-1:0]    cls;
        logic [LOW_W-1:0]    low;
        logic [LIMIT_W-1:0]  high;
        logic [SPREAD_W-1:0] spread;
        logic                last;
    } t_window_word;

    typedef logic [LIMIT_W-1:0] t_limit_set [CLASSES];

    logic i_clk;
    logic i_rst_n;

    pbwt_in_if  evt_if ();
    pbwt_out_if win_if ();
    pbwt_cfg_if cfg_if ();

    priority_backoff_window_table #(
        .CLASS_COUNT (CLASSES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_win   (win_if),
        .i_cfg   (cfg_if)
    );

    // shadow copy of the table
    logic [LIMIT_W-1:0]  limit_q  [CLASSES];
    logic [SPREAD_W-1:0] spread_q [CLASSES];
    logic [COLL_W-1:0]   coll_q   [CLASSES];
    int                  succ_q   [CLASSES];
    logic [LOW_W-1:0]    low_q    [CLASSES];
    logic [LIMIT_W-1:0]  high_q   [CLASSES];

    // expected window words, oldest at exp_head
    t_window_word expected_windows [WORD_SLOTS];
    int           exp_head;
    int           exp_tail;
    int           exp_count;
    int           errors;
    int           hold_cycles;
    bit           steady;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #RUN_LIMIT;
        $display("TB_ERROR");
        $finish;
    end

    // idle length: mostly none or short, a few long, none while steady
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // window top of one class, capped by its limit
    function automatic logic [LIMIT_W-1:0] capped_high(int c);
        int sum;
        sum = int'(low_q[c]) + int'(spread_q[c]);
        if (sum < int'(limit_q[c])) return LIMIT_W'(sum);
        return limit_q[c];
    endfunction

    // recompute one class, then chain every lower class below it
    function automatic void rechain_below(int top);
        high_q[top] = capped_high(top);
        for (int i = top; i > 0; i--) begin
            low_q[i-1]  = LOW_W'(high_q[i]) + 8'd1;
            high_q[i-1] = capped_high(i - 1);
        end
    endfunction

    function automatic void reset_windows();
        for (int i = 0; i < CLASSES; i++) begin
            limit_q[i]  = LIMIT_RESET[i];
            spread_q[i] = 5'd1;
            coll_q[i]   = '0;
            succ_q[i]   = 0;
            low_q[i]    = '0;
            high_q[i]   = '0;
        end
        low_q[CLASSES-1] = 8'd1;
        rechain_below(CLASSES - 1);
    endfunction

    // append one expected window word
    function automatic void expect_word(t_window_word w);
        if (exp_count == WORD_SLOTS) begin
            $error("expected window words overflow");
            errors++;
        end else begin
            expected_windows[exp_tail] = w;
            exp_tail = (exp_tail + 1) % WORD_SLOTS;
            exp_count++;
        end
    endfunction

    // apply one event and queue the eight window words it reports
    function automatic void predict_windows(logic mode, logic [CLS_W-1:0] cls);
        int           c;
        int           s;
        t_window_word w;
        c = int'(cls);
        if (mode == MODE_FAIL) begin
            if (coll_q[c] != COLL_MAX) coll_q[c] = coll_q[c] + 8'd1;
            if (coll_q[c] <= COLL_TABLE) spread_q[c] = SPREAD_UP[coll_q[c]];
            rechain_below(c);
        end else begin
            s = succ_q[c] + 1;
            if (s < int'(SUCC_WRAP)) begin
                succ_q[c] = s;
            end else begin
                // every third success narrows, windows stay as they are
                succ_q[c] = 0;
                if (coll_q[c] != '0) coll_q[c] = coll_q[c] - 8'd1;
                if (coll_q[c] <= COLL_TABLE) spread_q[c] = SPREAD_DOWN[coll_q[c]];
            end
        end
        for (int i = 0; i < CLASSES; i++) begin
            w.cls    = CLS_W'(i);
            w.low    = low_q[i];
            w.high   = high_q[i];
            w.spread = spread_q[i];
            w.last   = (i == CLASSES - 1);
            expect_word(w);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // window word checker
    always @(posedge i_clk) begin : check_windows
        t_window_word w;
        if (i_rst_n && win_if.valid && win_if.ready) begin
            if (exp_count == 0) begin
                $error("window word with none expected: class_index %0d", win_if.class_index);
                errors++;
            end else begin
                w = expected_windows[exp_head];
                exp_head = (exp_head + 1) % WORD_SLOTS;
                exp_count--;
                check_field("class_index", 32'(w.cls), 32'(win_if.class_index));
                check_field("window_low", 32'(w.low), 32'(win_if.window_low));
                check_field("window_high", 32'(w.high), 32'(win_if.window_high));
                check_field("spread", 32'(w.spread), 32'(win_if.spread));
                check_field("last", 32'(w.last), 32'(win_if.last));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        win_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                win_if.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                win_if.ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                win_if.ready <= 1'b0;
                stall_left = pick_gap();
            end else begin
                win_if.ready <= 1'b1;
            end
        end
    end

    // offer one event word and wait until it is taken; valid stays high afterwards
    task automatic send_event(logic mode, logic [CLS_W-1:0] cls);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_if.valid        <= 1'b1;
        evt_if.mode         <= mode;
        evt_if.priority_req <= cls;
        do @(posedge i_clk); while (!evt_if.ready);
        predict_windows(mode, cls);
    endtask

    // write every limit register in turn, only while the block is idle
    task automatic write_limits(t_limit_set values);
        for (int i = 0; i < CLASSES; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= CLS_W'(i);
            cfg_if.data  <= values[i];
            do @(posedge i_clk); while (!cfg_if.ready);
            limit_q[i] = values[i];
        end
        cfg_if.valid <= 1'b0;
    endtask

    // stop offering and wait until every expected window word has come
    task automatic settle();
        evt_if.valid <= 1'b0;
        while (exp_count != 0) @(posedge i_clk);
        repeat (DRAIN_MARGIN) @(posedge i_clk);
    endtask

    function automatic t_limit_set uniform_limits(logic [LIMIT_W-1:0] value);
        t_limit_set v;
        for (int i = 0; i < CLASSES; i++) v[i] = value;
        return v;
    endfunction

    // reset windows reported by events that change nothing
    task automatic test_reset_windows();
        send_event(MODE_SUCCESS, 3'd0);
        send_event(MODE_SUCCESS, 3'd5);
        settle();
    endtask

    // failures walk the spread up the table and past its end
    task automatic test_failure_ladder();
        repeat (6) send_event(MODE_FAIL, 3'd7);
        send_event(MODE_FAIL, 3'd0);
        send_event(MODE_FAIL, 3'd3);
        send_event(MODE_FAIL, 3'd3);
        settle();
    endtask

    // every third success narrows, from above the table, inside it and at zero
    task automatic test_success_narrowing();
        repeat (6) send_event(MODE_SUCCESS, 3'd7);
        repeat (3) send_event(MODE_SUCCESS, 3'd3);
        repeat (3) send_event(MODE_SUCCESS, 3'd1);
        send_event(MODE_FAIL, 3'd7);
        settle();
    endtask

    // limits at both ends, zero, and a write that waits for the next recompute
    task automatic test_limit_extremes();
        t_limit_set v;
        write_limits(uniform_limits(7'd127));
        send_event(MODE_FAIL, 3'd7);
        send_event(MODE_FAIL, 3'd4);
        settle();
        v    = uniform_limits(7'd127);
        v[0] = 7'd1;
        write_limits(v);
        send_event(MODE_SUCCESS, 3'd2);
        send_event(MODE_FAIL, 3'd0);
        settle();
        write_limits(uniform_limits(7'd1));
        send_event(MODE_FAIL, 3'd6);
        settle();
        write_limits(uniform_limits(7'd0));
        send_event(MODE_FAIL, 3'd7);
        settle();
        write_limits(LIMIT_RESET);
        send_event(MODE_FAIL, 3'd5);
        settle();
    endtask

    // collision count well above the table, then successes step it back into the table
    task automatic test_high_collision_count();
        steady = 1'b1;
        repeat (7) send_event(MODE_FAIL, 3'd2);
        repeat (9) send_event(MODE_SUCCESS, 3'd2);
        steady = 1'b0;
        settle();
    endtask

    // receiver holds off while events keep coming, then the sender waits for all words
    task automatic test_stalled_output();
        hold_cycles = HOLD_OFF;
        repeat (6) send_event(1'($urandom_range(0, 1)), CLS_W'($urandom_range(0, 7)));
        settle();
    endtask

    // random events over several limit settings, concentrated on one class per phase
    task automatic test_random_traffic();
        t_limit_set       v;
        logic [CLS_W-1:0] focus;
        logic [CLS_W-1:0] cls;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int i = 0; i < CLASSES; i++) begin
                case (p)
                    1:       v[i] = 7'd127;
                    2:       v[i] = LIMIT_W'($urandom_range(1, 24));
                    3:       v[i] = ($urandom_range(0, 3) == 0) ? 7'd0
                                                                : LIMIT_W'($urandom_range(0, 127));
                    default: v[i] = LIMIT_W'($urandom_range(1, 127));
                endcase
            end
            write_limits(v);
            steady = (p == 1);
            focus  = CLS_W'($urandom_range(0, 7));
            repeat (PHASE_EVENTS) begin
                cls = ($urandom_range(0, 1) == 0) ? focus : CLS_W'($urandom_range(0, 7));
                send_event(($urandom_range(0, 9) < 5) ? MODE_FAIL : MODE_SUCCESS, cls);
            end
            steady = 1'b0;
            settle();
        end
    endtask

    initial begin : run
        errors      = 0;
        hold_cycles = 0;
        steady      = 1'b0;
        exp_head    = 0;
        exp_tail    = 0;
        exp_count   = 0;
        i_rst_n             <= 1'b0;
        evt_if.valid        <= 1'b0;
        evt_if.mode         <= MODE_FAIL;
        evt_if.priority_req <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= '0;
        cfg_if.data         <= '0;
        reset_windows();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_reset_windows();
        test_failure_ladder();
        test_success_narrowing();
        test_limit_extremes();
        test_high_collision_count();
        test_stalled_output();
        test_random_traffic();

        settle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
